FILE: rtl/core/vmm_pkg.sv
// ============================================================================
// vmm_pkg
// Shared widths, command codes and the command word for the
// vector-matrix multiply.
// ============================================================================
package vmm_pkg;

    localparam int SIZE_W      = 7;
    localparam int IDX_W       = 6;
    localparam int DATA_W      = 16;
    localparam int PROD_W      = 32;
    localparam int ACC_W       = 40;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd4;

    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_MAC  = 2'd1;
    localparam logic [1:0] FUNC_READ = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef enum logic [1:0]
    {
        OP_LOAD,
        OP_MAC,
        OP_READ
    } op_t;

    typedef struct packed
    {
        op_t               op;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DATA_W-1:0] value;
    } cmd_t;

endpackage

FILE: rtl/core/vmm_ram.sv
// ============================================================================
// vmm_ram
// Generic one-write, one-read RAM with registered read data.
// ============================================================================
module vmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data <= mem[raddr];
    end

endmodule

FILE: rtl/core/vmm_front.sv
// ============================================================================
// vmm_front
// Input side: accepts words, range-checks them against the size in use
// and pushes the surviving commands into the queue.
// ============================================================================
module vmm_front
    import vmm_pkg::*;
(
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        func,
    input  logic [IDX_W-1:0]  row,
    input  logic [IDX_W-1:0]  col,
    input  logic [DATA_W-1:0] value,
    input  logic [SIZE_W-1:0] eff_n,
    input  logic              q_full,
    output logic              push,
    output cmd_t              push_cmd
);

    logic keep;
    logic row_ok;
    logic col_ok;

    assign in_stall = q_full;
    assign row_ok   = SIZE_W'(row) < eff_n;
    assign col_ok   = SIZE_W'(col) < eff_n;

    always_comb
    begin
        push_cmd.row   = row;
        push_cmd.col   = col;
        push_cmd.value = value;
        case (func)
            FUNC_LOAD:
            begin
                push_cmd.op = OP_LOAD;
                keep        = row_ok;
            end
            FUNC_MAC:
            begin
                push_cmd.op = OP_MAC;
                keep        = row_ok && col_ok;
            end
            FUNC_READ:
            begin
                push_cmd.op = OP_READ;
                keep        = 1'b1;
            end
            default:
            begin
                push_cmd.op = OP_READ;
                keep        = 1'b0;
            end
        endcase
    end

    assign push = in_valid && !q_full && keep;

endmodule

FILE: rtl/core/vmm_queue.sv
// ============================================================================
// vmm_queue
// Short command FIFO between the front and back ends.
// ============================================================================
module vmm_queue
    import vmm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    output logic q_valid,
    output cmd_t q_cmd,
    input  logic pop
);

    cmd_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full    = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign q_valid = count_reg != '0;
    assign q_cmd   = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: rtl/core/vmm_back.sv
// ============================================================================
// vmm_back
// Execution side: vector store, three-step multiply-accumulate pipe into
// the accumulator RAM, and the readout sequencer driving the result port.
// ============================================================================
module vmm_back
    import vmm_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SIZE_W-1:0] eff_n,
    input  logic              q_valid,
    input  cmd_t              q_cmd,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [IDX_W-1:0]  out_index,
    output logic [ACC_W-1:0]  out_value,
    output logic              last
);

    localparam int AW = $clog2(DEPTH);

    typedef enum logic [1:0]
    {
        ST_RUN,
        ST_ISSUE,
        ST_WAIT,
        ST_HOLD
    } state_t;

    state_t            state_reg;
    logic [AW-1:0]     k_reg;
    logic              out_valid_reg;
    logic [IDX_W-1:0]  out_index_reg;
    logic [ACC_W-1:0]  out_value_reg;
    logic              last_reg;

    logic              s1_vld_reg;
    logic              s1_row0_reg;
    logic [AW-1:0]     s1_col_reg;
    logic [DATA_W-1:0] s1_value_reg;
    logic              s1_accv_reg;

    logic              s2_vld_reg;
    logic              s2_row0_reg;
    logic [AW-1:0]     s2_col_reg;
    logic [PROD_W-1:0] s2_prod_reg;
    logic [ACC_W-1:0]  s2_acc_reg;

    logic [DEPTH-1:0]  acc_vld_reg;

    logic [AW-1:0]     hrow;
    logic [AW-1:0]     hcol;
    logic              hazard;
    logic              load_pop;
    logic              mac_pop;
    logic              read_pop;

    logic [DATA_W-1:0] vec_rd;
    logic [ACC_W-1:0]  acc_rd;
    logic [AW-1:0]     acc_raddr;
    logic [ACC_W-1:0]  acc_sum;
    logic [ACC_W-1:0]  prod_ext;
    logic [PROD_W-1:0] mul_a;
    logic [PROD_W-1:0] mul_b;
    logic [PROD_W-1:0] prod_next;

    assign hrow   = q_cmd.row[AW-1:0];
    assign hcol   = q_cmd.col[AW-1:0];
    assign hazard = (s1_vld_reg && (s1_col_reg == hcol)) ||
                    (s2_vld_reg && (s2_col_reg == hcol));

    always_comb
    begin
        load_pop = 1'b0;
        mac_pop  = 1'b0;
        read_pop = 1'b0;
        if (q_valid && (state_reg == ST_RUN))
        begin
            case (q_cmd.op)
                OP_LOAD: load_pop = 1'b1;
                OP_MAC:  mac_pop  = !hazard;
                OP_READ: read_pop = !s1_vld_reg && !s2_vld_reg;
                default: load_pop = 1'b0;
            endcase
        end
    end

    assign pop = load_pop || mac_pop || read_pop;

    vmm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_vec_ram (
        .clk     (clk),
        .we      (load_pop),
        .waddr   (hrow),
        .wdata   (q_cmd.value),
        .raddr   (hrow),
        .rd_data (vec_rd)
    );

    assign acc_raddr = (state_reg == ST_RUN) ? hcol : k_reg;

    vmm_ram #(
        .WIDTH (ACC_W),
        .DEPTH (DEPTH)
    ) u_acc_ram (
        .clk     (clk),
        .we      (s2_vld_reg),
        .waddr   (s2_col_reg),
        .wdata   (acc_sum),
        .raddr   (acc_raddr),
        .rd_data (acc_rd)
    );

    // exact 16x16 signed product in 32 bits
    assign mul_a     = {{(PROD_W-DATA_W){vec_rd[DATA_W-1]}}, vec_rd};
    assign mul_b     = {{(PROD_W-DATA_W){s1_value_reg[DATA_W-1]}}, s1_value_reg};
    assign prod_next = mul_a * mul_b;

    assign prod_ext = {{(ACC_W-PROD_W){s2_prod_reg[PROD_W-1]}}, s2_prod_reg};
    assign acc_sum  = s2_row0_reg ? prod_ext : s2_acc_reg + prod_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            acc_vld_reg <= '0;
        end
        else
        begin
            s1_vld_reg <= mac_pop;
            s2_vld_reg <= s1_vld_reg;
            if (s2_vld_reg)
            begin
                acc_vld_reg[s2_col_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_row0_reg  <= q_cmd.row == '0;
        s1_col_reg   <= hcol;
        s1_value_reg <= q_cmd.value;
        s1_accv_reg  <= acc_vld_reg[hcol];
        s2_row0_reg  <= s1_row0_reg;
        s2_col_reg   <= s1_col_reg;
        s2_prod_reg  <= prod_next;
        s2_acc_reg   <= s1_accv_reg ? acc_rd : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            out_index_reg <= '0;
            out_value_reg <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_RUN:
                begin
                    if (read_pop)
                    begin
                        k_reg     <= '0;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_ISSUE:
                begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    out_valid_reg <= 1'b1;
                    out_index_reg <= IDX_W'(k_reg);
                    out_value_reg <= acc_vld_reg[k_reg] ? acc_rd : '0;
                    last_reg      <= (SIZE_W'(k_reg) + SIZE_W'(1)) == eff_n;
                    state_reg     <= ST_HOLD;
                end
                ST_HOLD:
                begin
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        if (last_reg)
                        begin
                            state_reg <= ST_RUN;
                        end
                        else
                        begin
                            k_reg     <= k_reg + AW'(1);
                            state_reg <= ST_ISSUE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_RUN;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_value = out_value_reg;
    assign last      = last_reg;

endmodule

FILE: rtl/core/vector_matrix_multiply.sv
// ============================================================================
// vector_matrix_multiply
// out = v x M over an N by N matrix, N from the size register; Q8.8 inputs,
// Q24.16 results in 40-bit accumulators.
// ============================================================================
//
//  channel   handshake               payload
//  input     in_valid / in_stall     func, row, col, value
//  result    out_valid / out_stall   out_index, out_value, last
//  config    cfg_valid / cfg_ready   cfg_data (size_in_use)
//
//  Load and matrix words issue one per cycle outside readout; matrix words
//  pass s1 and s2, then are written. A matrix word to a column still in the
//  accumulate pipe waits until that column has left it (accumulator RAM
//  read-modify-write loop). A readout waits for the pipe to drain, then runs
//  ISSUE, WAIT, HOLD per result (registered RAM read), plus any out_stall
//  time. Accumulators read as zero after reset through per-entry valid bits.
//  A four-word command queue keeps accepting input during readout or stalls.
//
module vector_matrix_multiply
    import vmm_pkg::*;
#(
    parameter int MAX_SIZE = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [SIZE_W-1:0] cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        func,
    input  logic [IDX_W-1:0]  row,
    input  logic [IDX_W-1:0]  col,
    input  logic [DATA_W-1:0] value,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [IDX_W-1:0]  out_index,
    output logic [ACC_W-1:0]  out_value,
    output logic              last
);

    localparam int DEPTH = (MAX_SIZE < (1 << IDX_W)) ? MAX_SIZE : (1 << IDX_W);

    logic [SIZE_W-1:0] size_reg;
    logic [SIZE_W-1:0] eff_n;
    logic              q_full;
    logic              push;
    cmd_t              push_cmd;
    logic              q_valid;
    cmd_t              q_cmd;
    logic              pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            size_reg <= cfg_data;
        end
    end

    always_comb
    begin
        if (size_reg == '0)
        begin
            eff_n = SIZE_W'(1);
        end
        else if (size_reg > SIZE_W'(DEPTH))
        begin
            eff_n = SIZE_W'(DEPTH);
        end
        else
        begin
            eff_n = size_reg;
        end
    end

    vmm_front u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .func     (func),
        .row      (row),
        .col      (col),
        .value    (value),
        .eff_n    (eff_n),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    vmm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .pop      (pop)
    );

    vmm_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .eff_n     (eff_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_index (out_index),
        .out_value (out_value),
        .last      (last)
    );

`ifndef ASSERT_OFF
    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (SIZE_W'(out_index) < eff_n))
        else $error("result index beyond size in use");

    a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> ((SIZE_W'(out_index) + SIZE_W'(1)) == eff_n))
        else $error("last flag not on final column");

    a_no_pop_during_readout: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !pop)
        else $error("command issued while a result is pending");
`endif

endmodule
